// ----- sv/pgu_pkg.sv -----
package pgu_pkg;

  localparam int MAX_GRID    = 128;
  localparam int STEP_LIMIT  = 250;
  localparam int VALUE_WIDTH = 16;

  localparam int CELL_W      = 14;
  localparam int USED_W      = CELL_W + 1;
  localparam int GRID_W      = 8;
  localparam int FACTOR_W    = 9;
  localparam int COUNT_W     = 8;
  localparam int PROD_W      = VALUE_WIDTH + FACTOR_W;

  localparam logic [VALUE_WIDTH-1:0] TAU_FLOOR  = VALUE_WIDTH'(5120);
  localparam logic [VALUE_WIDTH-1:0] TAU_CAP    = VALUE_WIDTH'(51200);
  localparam logic [FACTOR_W-1:0]    FACTOR_ONE = FACTOR_W'(256);
  localparam logic [GRID_W-1:0]      GRID_MAX   = GRID_W'(MAX_GRID);
  localparam logic [COUNT_W-1:0]     COUNT_MAX  = COUNT_W'(STEP_LIMIT);

  typedef enum logic [1:0] {
    OP_EVAPORATE = 2'd0,
    OP_DEPOSIT   = 2'd1,
    OP_READ      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_EVAP_FACTOR = 2'd1;
  localparam logic [1:0] REG_TARGET_CELL = 2'd2;

  typedef struct packed {
    logic [GRID_W-1:0]   grid_width;
    logic [FACTOR_W-1:0] evaporation_factor;
    logic [CELL_W-1:0]   target_cell;
  } cfg_t;

  typedef struct packed {
    logic load;       // transfer accepted: latch item, issue cell read
    logic clear;      // clearing pass: write floor value at sweep address
    logic evap_run;   // evaporation walk: issue reads
    logic exec;       // read/deposit: data back, compute and respond
    logic evap_done;  // evaporation drained: respond
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic evap_issued;
    logic pipe_empty;
  } dp_status_t;

endpackage

// ----- sv/pgu_ctrl.sv -----
module pgu_ctrl
  import pgu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] operation,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_EVAP  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t state, state_next;
  op_t    op_in;

  assign op_in = op_t'(operation);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          state_next = (op_in == OP_EVAPORATE) ? S_EVAP : S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      S_EVAP: begin
        if (status.evap_issued) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (status.pipe_empty) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign busy          = (state != S_IDLE);
  assign cmd.load      = (state == S_IDLE) && start;
  assign cmd.clear     = (state == S_CLEAR);
  assign cmd.evap_run  = (state == S_EVAP);
  assign cmd.exec      = (state == S_EXEC);
  assign cmd.evap_done = (state == S_DRAIN) && status.pipe_empty;

endmodule

// ----- sv/pgu_datapath.sv -----
module pgu_datapath
  import pgu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  input  cfg_t                   cfg,
  input  logic [1:0]             operation,
  input  logic [CELL_W-1:0]      cell_index,
  input  logic [VALUE_WIDTH-1:0] deposit_amount,
  input  logic                   path_start,
  output dp_status_t             status,
  output logic [VALUE_WIDTH-1:0] pheromone,
  output logic                   accepted,
  output logic                   path_done,
  output logic                   done
);

  localparam int STORE_CELLS = 1 << CELL_W;

  logic [VALUE_WIDTH-1:0] mem [STORE_CELLS];
  logic [VALUE_WIDTH-1:0] rd_data;

  // latched item
  op_t                    op_q;
  logic [CELL_W-1:0]      cell_q;
  logic [VALUE_WIDTH-1:0] amount_q;
  logic                   start_q;

  // path state
  logic [COUNT_W-1:0] step_count;
  logic               path_finished;

  // sweep counters and evaporation pipeline
  logic [CELL_W-1:0]      clr_addr;
  logic [USED_W-1:0]      ev_addr;
  logic                   s1_valid, s2_valid;
  logic [CELL_W-1:0]      s1_addr, s2_addr;
  logic [PROD_W-1:0]      product;

  // derived values
  logic [GRID_W-1:0]      grid_eff;
  logic [2*GRID_W-1:0]    used_wide;
  logic [USED_W-1:0]      used;
  logic [FACTOR_W-1:0]    factor_eff;
  logic                   evap_issue;
  logic                   in_range;
  logic [VALUE_WIDTH-1:0] evap_scaled, evap_value;

  // exec results
  logic                   fin_eff, fin_c;
  logic [COUNT_W-1:0]     cnt_eff, cnt_c, cnt_inc;
  logic [VALUE_WIDTH:0]   dep_sum;
  logic [VALUE_WIDTH-1:0] dep_value, value_c;
  logic                   accepted_c, dep_write;

  assign grid_eff   = (cfg.grid_width > GRID_MAX) ? GRID_MAX : cfg.grid_width;
  assign used_wide  = {{GRID_W{1'b0}}, grid_eff} * {{GRID_W{1'b0}}, grid_eff};
  assign used       = used_wide[USED_W-1:0];
  assign factor_eff = (cfg.evaporation_factor > FACTOR_ONE) ? FACTOR_ONE
                                                            : cfg.evaporation_factor;
  assign evap_issue = cmd.evap_run && (ev_addr < used);
  assign in_range   = ({1'b0, cell_q} < used);

  assign status.clear_last  = (clr_addr == {CELL_W{1'b1}});
  assign status.evap_issued = (ev_addr >= used);
  assign status.pipe_empty  = !s1_valid && !s2_valid;

  // Product is Q8.8 * Q1.8; drop eight fraction bits, floor at 20.0.
  assign evap_scaled = product[VALUE_WIDTH+7:8];
  assign evap_value  = (evap_scaled < TAU_FLOOR) ? TAU_FLOOR : evap_scaled;

  // Read and deposit result, with path start on a deposit clearing the path state first.
  always_comb begin
    fin_eff    = start_q ? 1'b0 : path_finished;
    cnt_eff    = start_q ? '0 : step_count;
    cnt_inc    = (cnt_eff < COUNT_MAX) ? cnt_eff + 1'b1 : cnt_eff;
    dep_sum    = {1'b0, rd_data} + {1'b0, amount_q};
    dep_value  = (dep_sum >= {1'b0, TAU_CAP}) ? TAU_CAP : dep_sum[VALUE_WIDTH-1:0];
    value_c    = '0;
    accepted_c = 1'b0;
    dep_write  = 1'b0;
    fin_c      = path_finished;
    cnt_c      = step_count;
    case (op_q)
      OP_DEPOSIT: begin
        fin_c = fin_eff;
        cnt_c = cnt_eff;
        if (in_range) begin
          if (fin_eff) begin
            value_c = rd_data;
          end else begin
            value_c    = dep_value;
            accepted_c = 1'b1;
            dep_write  = 1'b1;
            cnt_c      = cnt_inc;
            fin_c      = (cell_q == cfg.target_cell) || (cnt_inc >= COUNT_MAX);
          end
        end
      end
      OP_READ: begin
        if (in_range) value_c = rd_data;
      end
      default: begin
        value_c = '0;
      end
    endcase
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= TAU_FLOOR;
    end else if (s2_valid) begin
      mem[s2_addr] <= evap_value;
    end else if (cmd.exec && dep_write) begin
      mem[cell_q] <= dep_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data <= mem[cell_index];
    end else if (evap_issue) begin
      rd_data <= mem[ev_addr[CELL_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op_t'(operation);
      cell_q   <= cell_index;
      amount_q <= deposit_amount;
      start_q  <= path_start;
    end
    s1_addr <= ev_addr[CELL_W-1:0];
    s2_addr <= s1_addr;
    product <= {{FACTOR_W{1'b0}}, rd_data} * {{VALUE_WIDTH{1'b0}}, factor_eff};
    if (cmd.exec) begin
      pheromone <= value_c;
      accepted  <= accepted_c;
      path_done <= fin_c;
    end else if (cmd.evap_done) begin
      pheromone <= '0;
      accepted  <= 1'b0;
      path_done <= path_finished;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      ev_addr       <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      step_count    <= '0;
      path_finished <= 1'b0;
      done          <= 1'b0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.load) begin
        ev_addr <= '0;
      end else if (evap_issue) begin
        ev_addr <= ev_addr + 1'b1;
      end
      s1_valid <= evap_issue;
      s2_valid <= s1_valid;
      if (cmd.exec) begin
        step_count    <= cnt_c;
        path_finished <= fin_c;
      end
      done <= cmd.exec || cmd.evap_done;
    end
  end

endmodule

// ----- sv/pheromone_grid_update.sv -----
// Pheromone grid store with evaporate, deposit and read commands.
//
// Command channel: drive operation, cell_index, deposit_amount and path_start
// with start high; the transfer happens at the rising edge where busy is low.
// Result channel: pheromone, accepted and path_done are valid for exactly one
// cycle while done is high; the receiver cannot stall, so take them then.
// Configuration: write wr_data into register wr_index (0 grid width,
// 1 evaporation factor, 2 target cell) at any edge with wr_en high, only
// while no command is in flight.
//
// A read or deposit shows its result after one registered memory read and one
// compute/write-back step; busy drops as done rises, so a new command can follow
// as soon as the last one reports done. Evaporate walks cells 0 .. w*w-1
// through the single memory read port, one cell a cycle, then drains a
// two-stage multiply pipeline before done rises.
//
// Reset: all 16384 cells of the store are swept to 20.0, one cell a cycle,
// with busy high; configuration registers return to 100, 179 and 0.
module pheromone_grid_update
  import pgu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             operation,
  input  logic [CELL_W-1:0]      cell_index,
  input  logic [VALUE_WIDTH-1:0] deposit_amount,
  input  logic                   path_start,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] pheromone,
  output logic                   accepted,
  output logic                   path_done,
  input  logic                   wr_en,
  input  logic [1:0]             wr_index,
  input  logic [CELL_W-1:0]      wr_data
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Configuration registers; a write to an unused index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width         <= GRID_W'(100);
      cfg.evaporation_factor <= FACTOR_W'(179);
      cfg.target_cell        <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_GRID_WIDTH:  cfg.grid_width         <= wr_data[GRID_W-1:0];
        REG_EVAP_FACTOR: cfg.evaporation_factor <= wr_data[FACTOR_W-1:0];
        REG_TARGET_CELL: cfg.target_cell        <= wr_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // Sequence clearing, command execution and the evaporation walk.
  pgu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Store, path state, arithmetic and result registers.
  pgu_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .operation      (operation),
    .cell_index     (cell_index),
    .deposit_amount (deposit_amount),
    .path_start     (path_start),
    .status         (status),
    .pheromone      (pheromone),
    .accepted       (accepted),
    .path_done      (path_done),
    .done           (done)
  );

endmodule

// ----- tb/sv/pheromone_grid_update_tb.sv -----
module pheromone_grid_update_tb;
  import pgu_pkg::*;

  localparam int STORE_CELLS    = MAX_GRID * MAX_GRID;
  // Longest quiet stretch of a correct run is the reset sweep or a full-grid
  // evaporation; allow several times that.
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int PHASE_ITEMS    = 40;
  localparam int N_PHASES       = 8;

  // One result as the block reports it.
  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic                   accepted;
    logic                   path_done;
  } cell_report_t;

  // Mirror of the pheromone store and path state; queues the report each
  // accepted command owes and compares it against the block's output.
  class pheromone_mirror;
    logic [VALUE_WIDTH-1:0] store [STORE_CELLS];
    int unsigned            steps;
    bit                     finished;
    logic [GRID_W-1:0]      grid_w;
    logic [FACTOR_W-1:0]    factor;
    logic [CELL_W-1:0]      target;
    cell_report_t           due_reports [$];
    int unsigned            op_count [4];
    int unsigned            reports_checked;
    int unsigned            mismatches;
    int unsigned            regs_written;

    function new();
      for (int i = 0; i < STORE_CELLS; i++) store[i] = TAU_FLOOR;
      steps           = 0;
      finished        = 0;
      grid_w          = 100;
      factor          = 179;
      target          = '0;
      reports_checked = 0;
      mismatches      = 0;
      regs_written    = 0;
      for (int i = 0; i < 4; i++) op_count[i] = 0;
    endfunction

    function int unsigned cells_used();
      int unsigned w;
      w = (grid_w > GRID_MAX) ? MAX_GRID : grid_w;
      return w * w;
    endfunction

    function int unsigned pending();
      return due_reports.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [CELL_W-1:0] val);
      case (idx)
        REG_GRID_WIDTH:  grid_w = val[GRID_W-1:0];
        REG_EVAP_FACTOR: factor = val[FACTOR_W-1:0];
        REG_TARGET_CELL: target = val;
        default: ;
      endcase
      regs_written++;
    endfunction

    // Note an accepted command: update the mirror and queue its report.
    function void apply_command(op_t op, logic [CELL_W-1:0] cell_id,
                                logic [VALUE_WIDTH-1:0] amount, logic first);
      cell_report_t r;
      int unsigned  used;
      int unsigned  f;
      int unsigned  t;
      r.value    = '0;
      r.accepted = 1'b0;
      used       = cells_used();
      op_count[op]++;
      case (op)
        OP_EVAPORATE: begin
          f = (factor > FACTOR_ONE) ? FACTOR_ONE : factor;
          for (int i = 0; i < used; i++) begin
            t = (store[i] * f) >> 8;
            if (t < TAU_FLOOR) t = TAU_FLOOR;
            store[i] = t[VALUE_WIDTH-1:0];
          end
        end
        OP_DEPOSIT: begin
          if (first) begin
            steps    = 0;
            finished = 0;
          end
          if (cell_id < used) begin
            if (finished) begin
              r.value = store[cell_id];
            end else begin
              t = store[cell_id] + amount;
              if (t >= TAU_CAP) t = TAU_CAP;
              store[cell_id] = t[VALUE_WIDTH-1:0];
              r.value        = t[VALUE_WIDTH-1:0];
              r.accepted     = 1'b1;
              if (steps < STEP_LIMIT) steps++;
              if (cell_id == target || steps >= STEP_LIMIT) finished = 1;
            end
          end
        end
        OP_READ: begin
          if (cell_id < used) r.value = store[cell_id];
        end
        default: ;
      endcase
      r.path_done = finished;
      due_reports.push_back(r);
    endfunction

    // Check one result against the oldest owed report.
    function void compare_report(logic [VALUE_WIDTH-1:0] ph, logic acc, logic pd);
      cell_report_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: result with nothing outstanding: pheromone %0d accepted %0d path_done %0d",
                 $time, ph, acc, pd);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      reports_checked++;
      if (ph !== want.value) begin
        $display("%0t: pheromone mismatch: expected %0d, actual %0d", $time, want.value, ph);
        mismatches++;
      end
      if (acc !== want.accepted) begin
        $display("%0t: accepted mismatch: expected %0d, actual %0d", $time, want.accepted, acc);
        mismatches++;
      end
      if (pd !== want.path_done) begin
        $display("%0t: path_done mismatch: expected %0d, actual %0d", $time, want.path_done, pd);
        mismatches++;
      end
    endfunction
  endclass

  // Block ports; every input has a known value from time zero.
  logic                   clk;
  logic                   rst            = 1'b1;
  logic                   start          = 1'b0;
  logic                   busy;
  logic [1:0]             operation      = OP_READ;
  logic [CELL_W-1:0]      cell_index     = '0;
  logic [VALUE_WIDTH-1:0] deposit_amount = '0;
  logic                   path_start     = 1'b0;
  logic                   done;
  logic [VALUE_WIDTH-1:0] pheromone;
  logic                   accepted;
  logic                   path_done;
  logic                   wr_en          = 1'b0;
  logic [1:0]             wr_index       = REG_GRID_WIDTH;
  logic [CELL_W-1:0]      wr_data        = '0;

  pheromone_grid_update dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .cell_index     (cell_index),
    .deposit_amount (deposit_amount),
    .path_start     (path_start),
    .done           (done),
    .pheromone      (pheromone),
    .accepted       (accepted),
    .path_done      (path_done),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data)
  );

  pheromone_mirror mirror;
  bit              allow_idle;   // cleared for the last phase of the run
  bit              idle_on;      // toggles so that idle stretches alternate with busy ones
  int              stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Take every result in the one cycle it is shown; the receiver never stalls.
  always @(posedge clk) begin
    if (!rst && done) mirror.compare_report(pheromone, accepted, path_done);
  end

  // Count cycles with no transfer on either side; give up when too many pass.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drop start and hold it off for the idle gap given by n.
  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Present one command and hold it until the block takes it. Start stays high
  // afterward so a following command can go back to back.
  task automatic cmd(op_t op, logic [CELL_W-1:0] cell_id,
                     logic [VALUE_WIDTH-1:0] amount, logic first);
    if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
    if (allow_idle && idle_on && $urandom_range(0, 1) == 1) idle_gap($urandom_range(1, 10));
    start          <= 1'b1;
    operation      <= op;
    cell_index     <= cell_id;
    deposit_amount <= amount;
    path_start     <= first;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.apply_command(op, cell_id, amount, first);
  endtask

  // Drop start and wait until every owed result has come back.
  task automatic settle();
    start <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CELL_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    mirror.set_reg(idx, val);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram all registers with the block idle.
  task automatic configure(int gw, int f, int tgt);
    settle();
    write_reg(REG_GRID_WIDTH, CELL_W'(gw));
    write_reg(REG_EVAP_FACTOR, CELL_W'(f));
    write_reg(REG_TARGET_CELL, CELL_W'(tgt));
  endtask

  function automatic logic [CELL_W-1:0] pick_cell(int unsigned used);
    if (used == 0) return CELL_W'($urandom);
    return CELL_W'($urandom_range(0, used - 1));
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] pick_amount();
    if ($urandom_range(0, 3) == 0) return VALUE_WIDTH'($urandom);
    return VALUE_WIDTH'($urandom_range(0, 4095));
  endfunction

  // Mostly ant paths with random content, plus reads, rare evaporations and
  // noise (unused operation, cells beyond the grid, stray deposits).
  task automatic run_phase(int n_items);
    int              issued;
    int              kind;
    int              len;
    int unsigned     used;
    logic [CELL_W-1:0] cell_id;
    issued = 0;
    used   = mirror.cells_used();
    while (issued < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          // End about half of the paths on the target cell.
          cell_id = (k == len - 1 && $urandom_range(0, 1) == 1) ? mirror.target
                                                                : pick_cell(used);
          cmd(OP_DEPOSIT, cell_id, pick_amount(), k == 0);
        end
        issued += len;
      end else if (kind < 80) begin
        cmd(OP_READ, pick_cell(used), VALUE_WIDTH'($urandom), 1'($urandom));
        issued++;
      end else if (kind < 88) begin
        cmd(op_t'($urandom_range(1, 3)), CELL_W'($urandom), VALUE_WIDTH'($urandom),
            1'($urandom));
        issued++;
      end else if (kind < 92) begin
        // Keep full-grid evaporations rare; each walks thousands of cells.
        if (used <= 1024 || $urandom_range(0, 19) == 0) begin
          cmd(OP_EVAPORATE, CELL_W'($urandom), VALUE_WIDTH'($urandom), 1'($urandom));
          issued++;
        end
      end else begin
        cmd(OP_DEPOSIT, CELL_W'($urandom), VALUE_WIDTH'($urandom), 1'($urandom));
        issued++;
      end
    end
  endtask

  // One long path that never meets its target: it ends on the step limit and
  // the deposits after that are turned away.
  task automatic walk_to_step_limit();
    configure(16, 256, 16383);
    for (int k = 0; k < STEP_LIMIT + 5; k++) begin
      cmd(OP_DEPOSIT, CELL_W'($urandom_range(0, 255)), VALUE_WIDTH'($urandom_range(0, 255)),
          k == 0);
    end
    for (int k = 0; k < 4; k++) cmd(OP_READ, CELL_W'($urandom_range(0, 255)), '0, 1'b0);
    cmd(OP_EVAPORATE, '0, '0, 1'b0);
    cmd(OP_READ, CELL_W'($urandom_range(0, 255)), '0, 1'b0);
  endtask

  initial begin
    int gw;
    int f;
    int tgt;
    int w;
    mirror     = new();
    allow_idle = 1;
    idle_on    = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset settings: width 100, factor 179, target 0.
    cmd(OP_READ, 14'd0, '0, 1'b0);                    // reset value at first cell
    cmd(OP_READ, 14'd9999, 16'hFFFF, 1'b1);           // last cell in use
    cmd(OP_READ, 14'd10000, '0, 1'b0);                // first cell past the grid
    cmd(OP_READ, 14'h3FFF, '0, 1'b0);                 // top of the index range
    cmd(OP_DEPOSIT, 14'd5, 16'h0100, 1'b1);           // open a path
    cmd(OP_DEPOSIT, 14'd9999, 16'hFFFF, 1'b0);        // saturate at the cap
    cmd(OP_DEPOSIT, 14'd5, 16'h0000, 1'b0);           // zero amount
    cmd(OP_DEPOSIT, 14'd0, 16'h0080, 1'b0);           // reach the target
    cmd(OP_DEPOSIT, 14'd7, 16'h0200, 1'b0);           // path over: turned away
    cmd(OP_DEPOSIT, 14'd10000, 16'h0200, 1'b0);       // off the grid
    cmd(OP_DEPOSIT, 14'h3FFF, 16'h0200, 1'b1);        // off the grid, still restarts
    cmd(OP_DEPOSIT, 14'd3, 16'hAAAA, 1'b0);           // taken on the restarted path
    cmd(OP_NONE, 14'd3, 16'h5555, 1'b1);              // unused operation
    cmd(OP_EVAPORATE, '0, '0, 1'b0);
    cmd(OP_READ, 14'd9999, '0, 1'b0);
    cmd(OP_READ, 14'd5, '0, 1'b0);
    cmd(OP_READ, 14'd3, '0, 1'b0);

    // Zero width: nothing is in use.
    configure(0, 0, 0);
    cmd(OP_READ, 14'd0, '0, 1'b0);
    cmd(OP_DEPOSIT, 14'd0, 16'h0100, 1'b1);
    cmd(OP_EVAPORATE, '0, '0, 1'b0);

    // Width beyond the maximum and a factor above one.
    configure(255, 511, 16383);
    cmd(OP_READ, 14'h3FFF, '0, 1'b0);
    cmd(OP_DEPOSIT, 14'h3FFF, 16'h1234, 1'b1);
    cmd(OP_EVAPORATE, '0, '0, 1'b0);
    cmd(OP_READ, 14'd9999, '0, 1'b0);

    // Zero factor drives every cell to the floor.
    configure(128, 0, 1);
    cmd(OP_EVAPORATE, '0, '0, 1'b0);
    cmd(OP_READ, 14'd9999, '0, 1'b0);

    walk_to_step_limit();

    // Random phases over a spread of settings; the last one runs without idling.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin gw = 1;   f = 0;                         end
        1: begin gw = 3;   f = 511;                       end
        2: begin gw = 8;   f = $urandom_range(1, 255);    end
        3: begin gw = 12;  f = 256;                       end
        4: begin gw = 255; f = 179;                       end
        5: begin gw = 6;   f = $urandom_range(257, 511);  end
        6: begin gw = 128; f = $urandom_range(0, 511);    end
        default: begin gw = 10; f = 128;                  end
      endcase
      w   = (gw > MAX_GRID) ? MAX_GRID : gw;
      tgt = (p == 3) ? 16383 : $urandom_range(0, w * w - 1);
      if (p == N_PHASES - 1) allow_idle = 0;
      configure(gw, f, tgt);
      run_phase(PHASE_ITEMS);
    end

    // Drain, then give the block a few more cycles to show anything stray.
    start <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, mirror.pending());
      mirror.mismatches += mirror.pending();
    end

    $display("Ran %0d commands: %0d evaporate, %0d deposit, %0d read, %0d unused.",
             mirror.op_count[OP_EVAPORATE] + mirror.op_count[OP_DEPOSIT] +
             mirror.op_count[OP_READ] + mirror.op_count[OP_NONE],
             mirror.op_count[OP_EVAPORATE], mirror.op_count[OP_DEPOSIT],
             mirror.op_count[OP_READ], mirror.op_count[OP_NONE]);
    $display("Checked %0d results across %0d register writes; %0d mismatches.",
             mirror.reports_checked, mirror.regs_written, mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pgu_pkg.sv
sv/pgu_ctrl.sv
sv/pgu_datapath.sv
sv/pheromone_grid_update.sv
tb/sv/pheromone_grid_update_tb.sv
